@@ rtl/core/vrt_pkg.sv @@
package vrt_pkg;

   // parametric t: unsigned Q16.32 in 48 bits
   localparam int T_BITS = 48;
   localparam int T_FRAC = 32;
   localparam logic [T_BITS-1:0] T_ALL = {T_BITS{1'b1}};
   localparam logic [T_BITS-1:0] T_ONE = T_BITS'(1) << T_FRAC;

   localparam int NUM_AXES = 3;
   localparam int CNT_W = 7;
   localparam logic [CNT_W-1:0] CSR_RESET = 7'd64;

   // division ops: axis = op / 2, odd op is the first-boundary t, even the step t
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_FIRST = 3'd0;
   localparam logic [OP_W-1:0] OP_END = 3'd6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_PREP,
      ST_DIV_SET,
      ST_DIV_RUN,
      ST_LOAD,
      ST_SEND,
      ST_STEP
   } vrt_state_type;

   typedef struct packed {
      logic            load;
      logic            diff;
      logic            prep;
      logic            div_load;
      logic            div_step;
      logic            div_store;
      logic            out_load;
      logic            step;
      logic [OP_W-1:0] op;
   } vrt_cmd_type;

   typedef struct packed {
      logic [NUM_AXES-1:0] moving;
      logic                div_done;
      logic                out_last;
   } vrt_stat_type;

endpackage

@@ rtl/core/vrt_if.sv @@
interface vrt_req_if #(
   parameter int COORD_W = 40
);
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] start_x;
   logic [COORD_W-1:0] start_y;
   logic [COORD_W-1:0] start_z;
   logic [COORD_W-1:0] end_x;
   logic [COORD_W-1:0] end_y;
   logic [COORD_W-1:0] end_z;

   modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                   input ready);
   modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                 output ready);
endinterface

interface vrt_rsp_if #(
   parameter int CELL_W = 24
);
   logic              valid;
   logic              ready;
   logic [CELL_W-1:0] cell_x;
   logic [CELL_W-1:0] cell_y;
   logic [CELL_W-1:0] cell_z;
   logic              last;
   logic              truncated;
   logic              degenerate;

   modport source (output valid, cell_x, cell_y, cell_z, last, truncated, degenerate,
                   input ready);
   modport sink (input valid, cell_x, cell_y, cell_z, last, truncated, degenerate,
                 output ready);
endinterface

@@ rtl/core/vrt_ctrl.sv @@
module vrt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  vrt_pkg::vrt_stat_type stat,
   output vrt_pkg::vrt_cmd_type  cmd
);
   import vrt_pkg::*;

   vrt_state_type   state_ff, state_in;
   logic [OP_W-1:0] op_ff, op_in;
   logic [1:0]      op_axis;

   assign op_axis = op_ff[2:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_FIRST;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DIFF;
         end
         ST_DIFF: state_in = ST_PREP;
         // moving flags land at the end of this cycle; DIV_SET skips still axes
         ST_PREP: begin
            op_in = OP_FIRST;
            state_in = ST_DIV_SET;
         end
         ST_DIV_SET: begin
            if (op_ff == OP_END) state_in = ST_LOAD;
            else if (stat.moving[op_axis]) state_in = ST_DIV_RUN;
            else op_in = op_ff + 3'd1;
         end
         ST_DIV_RUN: begin
            if (stat.div_done) begin
               state_in = ST_DIV_SET;
               op_in = op_ff + 3'd1;
            end
         end
         ST_LOAD: state_in = ST_SEND;
         ST_SEND: begin
            if (rsp_ready) state_in = stat.out_last ? ST_IDLE : ST_STEP;
         end
         ST_STEP: state_in = ST_LOAD;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      cmd.op = op_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         ST_DIFF: cmd.diff = 1'b1;
         ST_PREP: cmd.prep = 1'b1;
         ST_DIV_SET: begin
            cmd.div_load = (op_ff != OP_END) && stat.moving[op_axis];
         end
         ST_DIV_RUN: begin
            cmd.div_step  = !stat.div_done;
            cmd.div_store = stat.div_done;
         end
         ST_LOAD: cmd.out_load = 1'b1;
         ST_SEND: rsp_valid = 1'b1;
         ST_STEP: cmd.step = 1'b1;
         default: cmd = '0;
      endcase
   end

endmodule

@@ rtl/core/vrt_dp.sv @@
module vrt_dp #(
   parameter int MAX_CELLS = 64,
   parameter int INT_BITS  = 24,
   parameter int FRAC_BITS = 16
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  vrt_pkg::vrt_cmd_type                           cmd,
   output vrt_pkg::vrt_stat_type                          stat,
   input  logic                                           csr_wr_en,
   input  logic [vrt_pkg::CNT_W-1:0]                      csr_wr_data,
   input  logic [vrt_pkg::NUM_AXES-1:0][INT_BITS+FRAC_BITS-1:0] start_pt,
   input  logic [vrt_pkg::NUM_AXES-1:0][INT_BITS+FRAC_BITS-1:0] end_pt,
   output logic [vrt_pkg::NUM_AXES-1:0][INT_BITS-1:0]     out_cell,
   output logic                                           out_last,
   output logic                                           out_trunc,
   output logic                                           out_degen
);
   import vrt_pkg::*;

   localparam int CW   = INT_BITS + FRAC_BITS;
   localparam int AW   = CW + 1;                 // diffs, pushed start, |dir|
   localparam int NW   = FRAC_BITS + T_FRAC + 1; // dividend / quotient
   localparam int DCW  = $clog2(NW + 1);
   localparam logic [NW-1:0] STEP_DVD = NW'(1) << (FRAC_BITS + T_FRAC);
   localparam logic [DCW-1:0] DIV_LEN = DCW'(NW);
   localparam logic [FRAC_BITS:0] CELL_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

   logic [CNT_W-1:0] max_cells_ff;
   logic [CNT_W-1:0] cap_ff, cap_in;
   logic [CNT_W-1:0] n_ff;

   logic [NUM_AXES-1:0][CW-1:0]       s_ff, e_ff;
   logic [NUM_AXES-1:0][AW-1:0]       d_ff, sp_ff, adir_ff;
   logic [NUM_AXES-1:0]               up_ff, mov_ff;
   logic [NUM_AXES-1:0][INT_BITS-1:0] cell_ff;
   logic [NUM_AXES-1:0][T_BITS-1:0]   tn_ff, ts_ff;
   logic                              degen_ff;

   // shared restoring divider
   logic [NW-1:0]  dvd_ff, q_ff;
   logic [AW-1:0]  rem_ff, dsr_ff;
   logic [DCW-1:0] dcnt_ff;
   logic [AW:0]    trial;
   logic           q_bit;
   logic [NW+T_BITS-1:0] q_wide;
   logic [T_BITS-1:0]    q_sat;

   logic [1:0]     op_axis;
   logic [FRAC_BITS:0] fr, bnd_dist;

   // walk step
   logic [1:0]      ax;
   logic [T_BITS:0] tsum;
   logic            pending;

   assign op_axis = cmd.op[2:1];

   always_comb begin
      fr = {1'b0, sp_ff[op_axis][FRAC_BITS-1:0]};
      bnd_dist = up_ff[op_axis] ? (CELL_ONE - fr) : fr;
   end

   assign trial  = {rem_ff, dvd_ff[NW-1]};
   assign q_bit  = trial >= {1'b0, dsr_ff};
   assign q_wide = {{T_BITS{1'b0}}, q_ff};
   assign q_sat  = (|q_wide[NW+T_BITS-1:T_BITS]) ? T_ALL : q_wide[T_BITS-1:0];

   always_comb begin
      if (tn_ff[0] < tn_ff[1]) ax = (tn_ff[0] < tn_ff[2]) ? 2'd0 : 2'd2;
      else ax = (tn_ff[1] < tn_ff[2]) ? 2'd1 : 2'd2;
   end
   assign tsum = {1'b0, tn_ff[ax]} + {1'b0, ts_ff[ax]};
   assign pending = (tn_ff[0] <= T_ONE) || (tn_ff[1] <= T_ONE) || (tn_ff[2] <= T_ONE);

   always_comb begin
      if (max_cells_ff == '0) cap_in = CNT_W'(1);
      else if (max_cells_ff > CNT_W'(MAX_CELLS)) cap_in = CNT_W'(MAX_CELLS);
      else cap_in = max_cells_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) max_cells_ff <= CSR_RESET;
      else if (csr_wr_en) max_cells_ff <= csr_wr_data;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         s_ff <= start_pt;
         e_ff <= end_pt;
      end
      if (cmd.diff) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            d_ff[a] <= {e_ff[a][CW-1], e_ff[a]} - {s_ff[a][CW-1], s_ff[a]};
         end
      end
      if (cmd.prep) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            logic up, dn;
            logic [AW-1:0] sgv, spv;
            up = !d_ff[a][AW-1] && (d_ff[a] != '0);
            dn = d_ff[a][AW-1];
            sgv = up ? AW'(1) : (dn ? {AW{1'b1}} : '0);
            spv = {s_ff[a][CW-1], s_ff[a]} - sgv;
            up_ff[a]   <= up;
            mov_ff[a]  <= up | dn;
            sp_ff[a]   <= spv;
            adir_ff[a] <= dn ? (~d_ff[a] + AW'(3)) : (d_ff[a] + AW'(2));
            cell_ff[a] <= spv[FRAC_BITS +: INT_BITS];
            tn_ff[a]   <= T_ALL;
            ts_ff[a]   <= T_ALL;
         end
         degen_ff <= (d_ff[0] == '0) && (d_ff[1] == '0) && (d_ff[2] == '0);
         n_ff     <= CNT_W'(1);
         cap_ff   <= cap_in;
      end
      if (cmd.div_load) begin
         dvd_ff  <= cmd.op[0] ? (NW'(bnd_dist) << T_FRAC) : STEP_DVD;
         dsr_ff  <= adir_ff[op_axis];
         rem_ff  <= '0;
         q_ff    <= '0;
         dcnt_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff  <= q_bit ? AW'(trial - {1'b0, dsr_ff}) : trial[AW-1:0];
         q_ff    <= {q_ff[NW-2:0], q_bit};
         dvd_ff  <= {dvd_ff[NW-2:0], 1'b0};
         dcnt_ff <= dcnt_ff + DCW'(1);
      end
      if (cmd.div_store) begin
         if (cmd.op[0]) tn_ff[op_axis] <= q_sat;
         else ts_ff[op_axis] <= q_sat;
      end
      if (cmd.step) begin
         cell_ff[ax] <= up_ff[ax] ? (cell_ff[ax] + INT_BITS'(1))
                                  : (cell_ff[ax] - INT_BITS'(1));
         tn_ff[ax]   <= tsum[T_BITS] ? T_ALL : tsum[T_BITS-1:0];
         n_ff        <= n_ff + CNT_W'(1);
      end
      if (cmd.out_load) begin
         out_cell  <= cell_ff;
         out_last  <= !pending || (n_ff >= cap_ff);
         out_trunc <= pending && (n_ff >= cap_ff);
         out_degen <= degen_ff;
      end
   end

   assign stat.moving   = mov_ff;
   assign stat.div_done = (dcnt_ff == DIV_LEN);
   assign stat.out_last = out_last;

endmodule

@@ rtl/core/voxel_ray_traversal_core.sv @@
// Channel  Dir  Handshake    Payload
// req_     in   valid/ready  start_x/y/z, end_x/y/z (signed Q24.16)
// rsp_     out  valid/ready  cell_x/y/z, last, truncated, degenerate
// csr_     in   wr_en only   max_cells (7 bits)
//
// One ray at a time. Setup (diff, prep) comes first, then each moving axis
// runs two bit-serial divisions on the shared divider; a still axis skips
// its divisions. Each cell then passes through load, transfer and step,
// and the transfer waits out any response stall.
// Reset is synchronous; max_cells returns to 64. A stalled response holds
// its register and the walk waits; req_ready is high only while idle.
module voxel_ray_traversal_core #(
   parameter int MAX_CELLS = 64,
   parameter int INT_BITS  = 24,
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   vrt_req_if.sink                     req_chan,
   vrt_rsp_if.source                   rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [vrt_pkg::CNT_W-1:0]   csr_wr_data
);
   import vrt_pkg::*;

   localparam int CW = INT_BITS + FRAC_BITS;

   vrt_cmd_type  cmd;
   vrt_stat_type stat;

   logic [NUM_AXES-1:0][CW-1:0]       start_pt, end_pt;
   logic [NUM_AXES-1:0][INT_BITS-1:0] out_cell;

   assign start_pt = {req_chan.start_z, req_chan.start_y, req_chan.start_x};
   assign end_pt   = {req_chan.end_z, req_chan.end_y, req_chan.end_x};

   // sequencer: setup, divisions per axis, then one cell per transfer
   vrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // push-out, t setup divider, walk registers and output register
   vrt_dp #(
      .MAX_CELLS (MAX_CELLS),
      .INT_BITS  (INT_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .start_pt    (start_pt),
      .end_pt      (end_pt),
      .out_cell    (out_cell),
      .out_last    (rsp_chan.last),
      .out_trunc   (rsp_chan.truncated),
      .out_degen   (rsp_chan.degenerate)
   );

   assign rsp_chan.cell_x = out_cell[0];
   assign rsp_chan.cell_y = out_cell[1];
   assign rsp_chan.cell_z = out_cell[2];

endmodule

@@ sim/voxel_ray_traversal_core_tb.sv @@
`timescale 1ns / 1ps

module voxel_ray_traversal_core_tb;
   import vrt_pkg::*;

   localparam int COORD_W    = 40;
   localparam int CELL_W     = 24;
   localparam int FRAC_W     = 16;
   localparam int CAP_MAX    = 64;
   // longest legal quiet stretch: six bit-serial divisions,
   // a long response stall and a long request gap, taken several times over
   localparam int IDLE_LIMIT = 4000;
   localparam int DRAIN_WAIT = 40;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type sx, sy, sz;
      coord_type ex, ey, ez;
   } ray_type;

   typedef struct packed {
      logic [CELL_W-1:0] cx, cy, cz;
      logic              last;
      logic              truncated;
      logic              degenerate;
   } cell_result_type;

   typedef struct packed {
      ray_type         ray;
      logic            typed;
      cell_result_type want;
   } dir_row_type;

   typedef enum int {RK_SHORT, RK_DIAG, RK_TINY, RK_WIDE, RK_ZERO} ray_kind_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CNT_W-1:0] csr_wr_data;

   vrt_req_if #(.COORD_W(COORD_W)) req_chan ();
   vrt_rsp_if #(.CELL_W(CELL_W))   rsp_chan ();

   voxel_ray_traversal_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan.sink),
      .rsp_chan    (rsp_chan.source),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 20 ns clock
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // shadow of the block's limit register and the pending cells
   logic [CNT_W-1:0] max_cells_shadow;
   cell_result_type  cell_queue[$];

   int mismatches  = 0;
   int rays_sent   = 0;
   int cells_seen  = 0;
   int trunc_seen  = 0;
   int degen_seen  = 0;
   int idle_cycles = 0;
   bit stall_off   = 1'b0;

   // Walk one segment the way the block does and queue every cell it visits.
   function automatic void trace_ray(input ray_type r);
      longint s[3], e[3], vox[3];
      longint sp, ep, adir, fr, bnd_dist;
      longint unsigned quo, sum;
      logic [T_BITS-1:0] t_next[3], t_step[3];
      int sg[3];
      int cap, n, ax;
      bit pending;
      cell_result_type walk[$];
      cell_result_type c;

      s[0] = r.sx; s[1] = r.sy; s[2] = r.sz;
      e[0] = r.ex; e[1] = r.ey; e[2] = r.ez;

      // zero-length segment: only the end cell, flagged
      if (s[0] == e[0] && s[1] == e[1] && s[2] == e[2]) begin
         c = '0;
         c.cx = CELL_W'(e[0] >>> FRAC_W);
         c.cy = CELL_W'(e[1] >>> FRAC_W);
         c.cz = CELL_W'(e[2] >>> FRAC_W);
         c.last = 1'b1;
         c.degenerate = 1'b1;
         cell_queue.push_back(c);
         return;
      end

      cap = max_cells_shadow;
      if (cap < 1) cap = 1;
      if (cap > CAP_MAX) cap = CAP_MAX;

      for (int a = 0; a < 3; a++) begin
         sg[a] = (e[a] > s[a]) ? 1 : ((e[a] < s[a]) ? -1 : 0);
         // ends pushed one LSB outward, kept wider than the inputs
         sp = s[a] - sg[a];
         ep = e[a] + sg[a];
         vox[a] = sp >>> FRAC_W;
         if (sg[a] == 0) begin
            t_step[a] = T_ALL;
            t_next[a] = T_ALL;
         end else begin
            adir = (ep > sp) ? ep - sp : sp - ep;
            fr   = sp & ((64'd1 << FRAC_W) - 1);
            bnd_dist = (sg[a] > 0) ? (64'd1 << FRAC_W) - fr : fr;
            quo  = (64'd1 << (FRAC_W + T_FRAC)) / longint'(adir);
            t_step[a] = (quo > T_ALL) ? T_ALL : quo[T_BITS-1:0];
            quo  = (longint'(bnd_dist) << T_FRAC) / longint'(adir);
            t_next[a] = (quo > T_ALL) ? T_ALL : quo[T_BITS-1:0];
         end
      end

      c = '0;
      c.cx = CELL_W'(vox[0]);
      c.cy = CELL_W'(vox[1]);
      c.cz = CELL_W'(vox[2]);
      walk.push_back(c);
      n = 1;
      pending = (t_next[0] <= T_ONE) || (t_next[1] <= T_ONE) || (t_next[2] <= T_ONE);
      while (pending && n < cap) begin
         // x only when strictly least, else y if below z, else z
         if (t_next[0] < t_next[1]) ax = (t_next[0] < t_next[2]) ? 0 : 2;
         else                       ax = (t_next[1] < t_next[2]) ? 1 : 2;
         vox[ax] += sg[ax];
         sum = {16'd0, t_next[ax]} + {16'd0, t_step[ax]};
         t_next[ax] = (sum > T_ALL) ? T_ALL : sum[T_BITS-1:0];
         c.cx = CELL_W'(vox[0]);
         c.cy = CELL_W'(vox[1]);
         c.cz = CELL_W'(vox[2]);
         walk.push_back(c);
         n++;
         pending = (t_next[0] <= T_ONE) || (t_next[1] <= T_ONE) || (t_next[2] <= T_ONE);
      end
      walk[walk.size()-1].last      = 1'b1;
      walk[walk.size()-1].truncated = pending;
      foreach (walk[i]) cell_queue.push_back(walk[i]);
   endfunction

   function automatic coord_type rand_coord();
      return coord_type'({$urandom, $urandom});
   endfunction

   // Random segment; most are short so the walk visits many cells.
   function automatic ray_type make_ray(input ray_kind_type kind);
      ray_type r;
      int span;
      r.sx = rand_coord();
      r.sy = rand_coord();
      r.sz = rand_coord();
      // keep most segments away from the coordinate edges
      if (kind != RK_WIDE && $urandom_range(0, 3) != 0) begin
         r.sx = r.sx >>> $urandom_range(8, 30);
         r.sy = r.sy >>> $urandom_range(8, 30);
         r.sz = r.sz >>> $urandom_range(8, 30);
      end
      case (kind)
         RK_SHORT: begin
            span = $urandom_range(1, 10) << FRAC_W;
            r.ex = r.sx + ($urandom_range(0, 4) == 0 ? 0
                                                     : int'($urandom_range(0, 2*span)) - span);
            r.ey = r.sy + ($urandom_range(0, 4) == 0 ? 0
                                                     : int'($urandom_range(0, 2*span)) - span);
            r.ez = r.sz + ($urandom_range(0, 4) == 0 ? 0
                                                     : int'($urandom_range(0, 2*span)) - span);
         end
         RK_DIAG: begin
            // equal moves give exact ties between axes
            span = $urandom_range(0, 8 << FRAC_W) - (4 << FRAC_W);
            r.sy = r.sx;
            r.sz = $urandom_range(0, 1) ? r.sx : r.sz;
            r.ex = r.sx + span;
            r.ey = r.sy + ($urandom_range(0, 1) ? span : -span);
            r.ez = r.sz + span;
         end
         RK_TINY: begin
            r.ex = r.sx + $urandom_range(0, 6) - 3;
            r.ey = r.sy + $urandom_range(0, 6) - 3;
            r.ez = r.sz + $urandom_range(0, 6) - 3;
         end
         RK_WIDE: begin
            r.ex = rand_coord();
            r.ey = rand_coord();
            r.ez = rand_coord();
         end
         default: begin
            r.ex = r.sx;
            r.ey = r.sy;
            r.ez = r.sz;
         end
      endcase
      return r;
   endfunction

   function automatic ray_kind_type pick_kind();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return RK_SHORT;
      if (roll < 70) return RK_DIAG;
      if (roll < 80) return RK_TINY;
      if (roll < 93) return RK_WIDE;
      return RK_ZERO;
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 3);
   endfunction

   // Present one segment; valid stays high afterward so back-to-back
   // transfers never drop it in between.
   task automatic send_ray(input ray_type r, input bit typed, input cell_result_type want);
      int gap;
      gap = stall_off ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.start_x <= r.sx;
      req_chan.start_y <= r.sy;
      req_chan.start_z <= r.sz;
      req_chan.end_x   <= r.ex;
      req_chan.end_y   <= r.ey;
      req_chan.end_z   <= r.ez;
      do @(posedge clock); while (!req_chan.ready);
      if (typed) cell_queue.push_back(want);
      else       trace_ray(r);
      rays_sent++;
   endtask

   // Limit writes happen only with nothing in flight.
   task automatic write_max_cells(input logic [CNT_W-1:0] value);
      @(posedge clock);
      req_chan.valid <= 1'b0;
      while (cell_queue.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      max_cells_shadow = value;
   endtask

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++) send_ray(make_ray(pick_kind()), 1'b0, '0);
   endtask

   // Response side: ready toggles in runs, mostly short stalls, a few long.
   int run_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         run_left <= 0;
      end else if (stall_off) begin
         rsp_chan.ready <= 1'b1;
      end else if (run_left > 0) begin
         run_left <= run_left - 1;
      end else if (!rsp_chan.ready) begin
         rsp_chan.ready <= 1'b1;
         run_left <= $urandom_range(0, 20);
      end else begin
         rsp_chan.ready <= 1'b0;
         run_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      end
   end

   // Check every cell transfer against the oldest pending cell.
   always @(posedge clock) begin
      cell_result_type got, exp_cell;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{rsp_chan.cell_x, rsp_chan.cell_y, rsp_chan.cell_z,
                 rsp_chan.last, rsp_chan.truncated, rsp_chan.degenerate};
         cells_seen++;
         if (got.truncated) trunc_seen++;
         if (got.degenerate) degen_seen++;
         if (cell_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected cell %h %h %h l%b t%b d%b", got.cx, got.cy, got.cz,
                        got.last, got.truncated, got.degenerate);
         end else begin
            exp_cell = cell_queue.pop_front();
            if (got !== exp_cell) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("cell %0d: exp %h %h %h l%b t%b d%b  got %h %h %h l%b t%b d%b",
                           cells_seen, exp_cell.cx, exp_cell.cy, exp_cell.cz,
                           exp_cell.last, exp_cell.truncated, exp_cell.degenerate,
                           got.cx, got.cy, got.cz, got.last, got.truncated, got.degenerate);
            end
         end
      end
   end

   // Watchdog: too long without any transfer ends the run.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   dir_row_type dir_rows[15];

   initial begin
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      req_chan.valid   = 1'b0;
      req_chan.start_x = '0;
      req_chan.start_y = '0;
      req_chan.start_z = '0;
      req_chan.end_x   = '0;
      req_chan.end_y   = '0;
      req_chan.end_z   = '0;
      max_cells_shadow = CSR_RESET;

      // zero-length rays: result readable by eye
      dir_rows[0] = '{'{40'sd0, 40'sd0, 40'sd0, 40'sd0, 40'sd0, 40'sd0}, 1'b1,
                      '{24'h000000, 24'h000000, 24'h000000, 1'b1, 1'b0, 1'b1}};
      dir_rows[1] = '{'{40'sh7FFFFFFFFF, 40'sh7FFFFFFFFF, 40'sh7FFFFFFFFF,
                        40'sh7FFFFFFFFF, 40'sh7FFFFFFFFF, 40'sh7FFFFFFFFF}, 1'b1,
                      '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1, 1'b0, 1'b1}};
      dir_rows[2] = '{'{40'sh8000000000, 40'sh8000000000, 40'sh8000000000,
                        40'sh8000000000, 40'sh8000000000, 40'sh8000000000}, 1'b1,
                      '{24'h800000, 24'h800000, 24'h800000, 1'b1, 1'b0, 1'b1}};
      dir_rows[3] = '{'{-40'sd1, -40'sd1, -40'sd1, -40'sd1, -40'sd1, -40'sd1}, 1'b1,
                      '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b0, 1'b1}};
      // single-axis moves, each direction
      dir_rows[4] = '{'{40'sd0, 40'sd0, 40'sd0, 40'sh30000, 40'sd0, 40'sd0}, 1'b0, '0};
      dir_rows[5] = '{'{40'sd0, 40'sh28000, 40'sd0, 40'sd0, -40'sh18000, 40'sd0}, 1'b0, '0};
      dir_rows[6] = '{'{40'sh8000, 40'sd0, 40'sh48000, 40'sh8000, 40'sd0, 40'sh8000}, 1'b0, '0};
      // exact ties between axes
      dir_rows[7] = '{'{40'sd0, 40'sd0, 40'sd0, 40'sh28000, 40'sh28000, 40'sh28000}, 1'b0, '0};
      dir_rows[8] = '{'{40'sh8000, 40'sh8000, 40'sd0, 40'sh38000, 40'sh38000, 40'sh10000},
                      1'b0, '0};
      // one-LSB segment
      dir_rows[9] = '{'{40'sd0, 40'sd0, 40'sd0, 40'sd1, 40'sd0, 40'sd0}, 1'b0, '0};
      // corner to corner: the walk hits the limit
      dir_rows[10] = '{'{40'sh8000000000, 40'sh8000000000, 40'sh8000000000,
                         40'sh7FFFFFFFFF, 40'sh7FFFFFFFFF, 40'sh7FFFFFFFFF}, 1'b0, '0};
      dir_rows[11] = '{'{40'sh7FFFFFFFFF, 40'sd0, 40'sh8000000000,
                         40'sh8000000000, 40'sd5, 40'sh7FFFFFFFFF}, 1'b0, '0};
      // crossing zero from negative fractions
      dir_rows[12] = '{'{-40'sh18000, -40'sh4000, 40'sh12345, 40'sh18000, 40'sh24000,
                         -40'sh21234}, 1'b0, '0};
      // start on a boundary moving down
      dir_rows[13] = '{'{40'sh10000, 40'sh20000, 40'sd0, 40'sd0, 40'sd0, 40'sd0}, 1'b0, '0};
      // near the top edge: pushed end runs past the field range
      dir_rows[14] = '{'{40'sh7FFFFD0000, 40'sd0, 40'sd0, 40'sh7FFFFFFFFF, 40'sh1000,
                         40'sd0}, 1'b0, '0};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_ray(dir_rows[i].ray, dir_rows[i].typed, dir_rows[i].want);

      // limit sweep: smallest, zero (acts as one), above range, default
      write_max_cells(7'd1);
      send_random(15);
      write_max_cells(7'd0);
      send_random(10);
      write_max_cells(7'd127);
      send_random(30);
      // a stretch with no idling on either side
      write_max_cells(7'd64);
      stall_off = 1'b1;
      send_random(20);
      stall_off = 1'b0;
      send_random(20);
      write_max_cells(7'($urandom_range(2, 63)));
      send_random(30);
      write_max_cells(7'($urandom_range(2, 63)));
      send_random(30);

      @(posedge clock);
      req_chan.valid <= 1'b0;
      while (cell_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("%0d rays sent, %0d cells checked (%0d truncated walks, %0d zero-length rays)",
               rays_sent, cells_seen, trunc_seen, degen_seen);
      $display("limit settings 1, 0, 127, 64 and two random values");
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/vrt_pkg.sv
rtl/core/vrt_if.sv
rtl/core/vrt_ctrl.sv
rtl/core/vrt_dp.sv
rtl/core/voxel_ray_traversal_core.sv
sim/voxel_ray_traversal_core_tb.sv
